// ===== sv/dda_line_rasterizer_defines.svh =====
// ----------------------------------------------------------------------------
// DDA line rasterizer assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication check.
`define DDA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dda assertion failed");

// Next-cycle implication check.
`define DDA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dda assertion failed");

`endif

// ===== sv/dda_pkg.sv =====
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Coordinate widths, sequencer states and the axis state record.
// ----------------------------------------------------------------------------
package dda_pkg;

  // Coordinate bits actually used from each endpoint field.
  localparam int COORD_BITS = 6;
  // Width of the coordinate fields on the ports.
  localparam int FIELD_W    = 6;
  localparam int GLYPH_W    = 8;

  // Signed difference of two coordinates and the remainder-plus-delta sum.
  localparam int DELTA_W = COORD_BITS + 1;
  localparam int SUM_W   = COORD_BITS + 2;

  typedef logic [COORD_BITS-1:0]    coord_t;
  typedef logic signed [DELTA_W-1:0] delta_t;

  // Position and remainder of one axis of the line.
  typedef struct packed {
    coord_t pos;
    coord_t rem;
  } dda_axis_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } dda_state_e;

endpackage

// ===== sv/dda_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Turns one line request into the run of pixels of an exact DDA line.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one line per transaction: both endpoints and a
//   glyph code. The master stream gives one pixel per transaction, with
//   tlast on the final pixel of the line.
//   A line of steps = max(|dx|, |dy|) yields steps + 1 pixels. After the
//   accepting edge the setup state computes the deltas and step count; then
//   the pixel sequencer emits one pixel a cycle, while the receiver keeps up,
//   through the output register. The rate is set by the single minor-axis
//   step unit, used once per pixel. s_axis_tready is high only while no
//   line is in work; the next line may be taken while the final pixel
//   still waits in the output register. When the receiver stalls, the
//   pixel is held and the sequencer waits. Reset empties the output
//   register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`include "dda_line_rasterizer_defines.svh"

module dda_line_rasterizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: x_from[5:0], y_from[11:6], x_to[17:12], y_to[23:18],
  // glyph[31:24].
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: pix_x[5:0], pix_y[11:6], pix_glyph[19:12], zero pad.
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int CB = dda_pkg::COORD_BITS;

  dda_pkg::dda_state_e state_q, state_d;

  // Line registers.
  dda_pkg::coord_t  x0_q, y0_q, x1_q, y1_q;
  logic [dda_pkg::GLYPH_W-1:0] glyph_q;
  dda_pkg::coord_t  steps_q, cnt_q;
  dda_pkg::delta_t  dminor_q;
  logic             xmaj_q;
  logic             majneg_q;
  dda_pkg::coord_t  pmaj_q;
  dda_pkg::dda_axis_t minor_q, minor_nxt;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  logic [dda_pkg::FIELD_W-1:0] out_x_q, out_y_q;
  logic [dda_pkg::GLYPH_W-1:0] out_g_q;
  logic                       out_last_q;

  logic            accept;
  logic            emit;
  logic            is_last;
  dda_pkg::delta_t dx, dy;
  dda_pkg::coord_t ax, ay;
  dda_pkg::coord_t cur_x, cur_y;

  // Sequencer next state and handshake.
  always_comb begin
    state_d       = state_q;
    s_axis_tready = (state_q == dda_pkg::ST_IDLE);
    accept        = s_axis_tvalid && s_axis_tready;
    emit          = (state_q == dda_pkg::ST_RUN) && (!out_valid_q || m_axis_tready);
    is_last       = (cnt_q == steps_q);
    case (state_q)
      dda_pkg::ST_IDLE:  if (accept) state_d = dda_pkg::ST_SETUP;
      dda_pkg::ST_SETUP: state_d = dda_pkg::ST_RUN;
      dda_pkg::ST_RUN:   if (emit && is_last) state_d = dda_pkg::ST_IDLE;
      default:           state_d = dda_pkg::ST_IDLE;
    endcase
    out_valid_d = emit ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dda_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Deltas, magnitudes and current pixel position.
  always_comb begin
    dx    = signed'({1'b0, x1_q}) - signed'({1'b0, x0_q});
    dy    = signed'({1'b0, y1_q}) - signed'({1'b0, y0_q});
    ax    = dx[dda_pkg::DELTA_W-1] ? CB'(-dx) : CB'(dx);
    ay    = dy[dda_pkg::DELTA_W-1] ? CB'(-dy) : CB'(dy);
    cur_x = xmaj_q ? pmaj_q : minor_q.pos;
    cur_y = xmaj_q ? minor_q.pos : pmaj_q;
  end

  // Step unit for the minor axis.
  dda_axis_unit u_axis (
    .cur_i   (minor_q),
    .delta_i (dminor_q),
    .steps_i (steps_q),
    .nxt_o   (minor_nxt)
  );

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x0_q    <= s_axis_tdata[CB-1:0];
      y0_q    <= s_axis_tdata[6 +: CB];
      x1_q    <= s_axis_tdata[12 +: CB];
      y1_q    <= s_axis_tdata[18 +: CB];
      glyph_q <= s_axis_tdata[31:24];
    end
    if (state_q == dda_pkg::ST_SETUP) begin
      xmaj_q      <= (ax >= ay);
      steps_q     <= (ax >= ay) ? ax : ay;
      dminor_q    <= (ax >= ay) ? dy : dx;
      majneg_q    <= (ax >= ay) ? dx[dda_pkg::DELTA_W-1] : dy[dda_pkg::DELTA_W-1];
      pmaj_q      <= (ax >= ay) ? x0_q : y0_q;
      minor_q.pos <= (ax >= ay) ? y0_q : x0_q;
      minor_q.rem <= '0;
      cnt_q       <= '0;
    end
    // Emit the current pixel and, unless it is the last, step both axes.
    if (emit) begin
      out_x_q    <= dda_pkg::FIELD_W'(cur_x);
      out_y_q    <= dda_pkg::FIELD_W'(cur_y);
      out_g_q    <= glyph_q;
      out_last_q <= is_last;
      if (!is_last) begin
        pmaj_q  <= majneg_q ? pmaj_q - CB'(1) : pmaj_q + CB'(1);
        minor_q <= minor_nxt;
        cnt_q   <= cnt_q + CB'(1);
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_g_q, out_y_q, out_x_q};
  assign m_axis_tlast  = out_last_q;

  // A taken line always goes through setup next.
  `DDA_ASSERT_NXT(a_accept_setup, accept, state_q == dda_pkg::ST_SETUP)
  // The pixel counter never passes the step count.
  `DDA_ASSERT_IMP(a_cnt_range, state_q == dda_pkg::ST_RUN, cnt_q <= steps_q)
  // The minor remainder stays below the step count.
  `DDA_ASSERT_IMP(a_rem_range, state_q == dda_pkg::ST_RUN && steps_q != '0,
                  minor_q.rem < steps_q)

endmodule

// ===== sv/dda_axis_unit.sv =====
// ----------------------------------------------------------------------------
// DDA axis step unit
// Advances the minor axis by one pixel: adds the delta to the remainder and
// applies at most one correction by the step count.
// ----------------------------------------------------------------------------
module dda_axis_unit (
  input  dda_pkg::dda_axis_t cur_i,
  input  dda_pkg::delta_t    delta_i,
  input  dda_pkg::coord_t    steps_i,
  output dda_pkg::dda_axis_t nxt_o
);

  logic signed [dda_pkg::SUM_W-1:0] sum;
  logic signed [dda_pkg::SUM_W-1:0] steps_s;
  logic signed [dda_pkg::SUM_W-1:0] rem_s;

  // Remainder stays in [0, steps); the position moves by one when the sum leaves that range.
  always_comb begin
    steps_s = signed'({2'b00, steps_i});
    sum     = signed'({2'b00, cur_i.rem}) + dda_pkg::SUM_W'(delta_i);
    nxt_o   = cur_i;
    if (sum >= steps_s) begin
      rem_s     = sum - steps_s;
      nxt_o.pos = cur_i.pos + dda_pkg::COORD_BITS'(1);
    end else if (sum < 0) begin
      rem_s     = sum + steps_s;
      nxt_o.pos = cur_i.pos - dda_pkg::COORD_BITS'(1);
    end else begin
      rem_s     = sum;
    end
    nxt_o.rem = rem_s[dda_pkg::COORD_BITS-1:0];
  end

endmodule

// ===== sim/dda_pixel_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DDA pixel stream checker
// Watches both streams of the rasterizer. For every accepted line it
// predicts the exact run of pixels. It then compares each output transaction,
// in order, with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module dda_pixel_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  // Fields from bit 0: x_from, y_from, x_to, y_to, glyph.
  input  logic [31:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // Fields from bit 0: pix_x, pix_y, pix_glyph, zero pad.
  input  logic [23:0] m_axis_tdata_i,
  input  logic        m_axis_tlast_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          lines_o,
  output int          pixels_o
);

  typedef struct packed {
    logic [dda_pkg::FIELD_W-1:0] x;
    logic [dda_pkg::FIELD_W-1:0] y;
    logic [dda_pkg::GLYPH_W-1:0] glyph;
    logic                        last;
  } pixel_t;

  pixel_t expected_pixels[$];
  pixel_t want;
  pixel_t got;
  int     fail_count = 0;
  int     lines_seen = 0;
  int     pixels_seen = 0;
  int     pixels_waiting = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pixels_waiting;
  assign lines_o      = lines_seen;
  assign pixels_o     = pixels_seen;

  // One axis of the line: keep q*steps + r == delta*i with r in [0, steps).
  function automatic void advance_axis(input int delta, input int steps,
                                       inout int q, inout int r);
    r += delta;
    if (r >= steps) begin
      r -= steps;
      q += 1;
    end else if (r < 0) begin
      r += steps;
      q -= 1;
    end
  endfunction

  // Queue the whole pixel run of one line transaction.
  function automatic void rasterize_line(input logic [31:0] word);
    dda_pkg::coord_t             x_from;
    dda_pkg::coord_t             y_from;
    dda_pkg::coord_t             x_to;
    dda_pkg::coord_t             y_to;
    logic [dda_pkg::GLYPH_W-1:0] glyph;
    int                          dx;
    int                          dy;
    int                          steps;
    int                          qx;
    int                          rx;
    int                          qy;
    int                          ry;
    int                          col;
    int                          row;
    pixel_t                      px;
    // Only the low coordinate bits take part in the line.
    x_from = word[0 +: dda_pkg::COORD_BITS];
    y_from = word[6 +: dda_pkg::COORD_BITS];
    x_to   = word[12 +: dda_pkg::COORD_BITS];
    y_to   = word[18 +: dda_pkg::COORD_BITS];
    glyph  = word[31:24];
    dx     = int'(x_to) - int'(x_from);
    dy     = int'(y_to) - int'(y_from);
    steps  = (dx < 0) ? -dx : dx;
    if (((dy < 0) ? -dy : dy) > steps) begin
      steps = (dy < 0) ? -dy : dy;
    end
    qx = 0;
    rx = 0;
    qy = 0;
    ry = 0;
    // Equal endpoints give steps == 0 and so a single pixel.
    for (int i = 0; i <= steps; i++) begin
      if (i > 0) begin
        advance_axis(dx, steps, qx, rx);
        advance_axis(dy, steps, qy, ry);
      end
      col      = int'(x_from) + qx;
      row      = int'(y_from) + qy;
      px.x     = col[dda_pkg::FIELD_W-1:0];
      px.y     = row[dda_pkg::FIELD_W-1:0];
      px.glyph = glyph;
      px.last  = (i == steps);
      expected_pixels = {expected_pixels, px};
    end
  endfunction

  function automatic string pixel_text(input pixel_t px);
    return $sformatf("x=%0d y=%0d glyph=%02h last=%0b", px.x, px.y, px.glyph, px.last);
  endfunction

  function automatic void report_failure(input string what);
    if (fail_count < 10) begin
      $display("[%0t] %s", $realtime, what);
    end
    fail_count++;
  endfunction

  // Predict on every line transaction and check every pixel transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        rasterize_line(s_axis_tdata_i);
        lines_seen++;
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        pixels_seen++;
        got.x     = m_axis_tdata_i[5:0];
        got.y     = m_axis_tdata_i[11:6];
        got.glyph = m_axis_tdata_i[19:12];
        got.last  = m_axis_tlast_i;
        if (expected_pixels.size() == 0) begin
          report_failure($sformatf("pixel with no line pending: %s", pixel_text(got)));
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            report_failure($sformatf("pixel mismatch: expected %s, got %s",
                                     pixel_text(want), pixel_text(got)));
          end
        end
      end
      pixels_waiting = expected_pixels.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DDA line rasterizer testbench
// Drives line requests into the rasterizer. Directed corner lines come first,
// then random lines under three idling profiles and one long output stall.
// A separate checker predicts and compares every pixel.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LINES_PER_PHASE = 132;
  localparam int STALL_CYCLES    = 400;
  localparam int DRAIN_CYCLES    = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  int   send_idle_pct = 6;
  int   recv_idle_pct = 59;
  logic stall_go = 1'b0;
  logic rx_hold = 1'b0;
  int   fail_count;
  int   pending;
  int   lines_done;
  int   pixels_done;

  dda_line_rasterizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  dda_pixel_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .lines_o         (lines_done),
    .pixels_o        (pixels_done)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Reset at the start of the simulation only.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Pixel receiver: random back-pressure, and never ready while held off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long output stall so that the block fills up and stops taking lines.
  initial begin
    wait (stall_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Run watchdog.
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [31:0] pack_line(input logic [dda_pkg::FIELD_W-1:0] x_from,
                                            input logic [dda_pkg::FIELD_W-1:0] y_from,
                                            input logic [dda_pkg::FIELD_W-1:0] x_to,
                                            input logic [dda_pkg::FIELD_W-1:0] y_to,
                                            input logic [dda_pkg::GLYPH_W-1:0] glyph);
    return {glyph, y_to, x_to, y_from, x_from};
  endfunction

  // Mostly arbitrary lines, with short, straight and single-point ones mixed in.
  function automatic logic [31:0] random_line();
    int kind;
    int x_from;
    int y_from;
    int x_to;
    int y_to;
    int len;
    int glyph;
    kind   = $urandom_range(99);
    x_from = $urandom_range(63);
    y_from = $urandom_range(63);
    x_to   = $urandom_range(63);
    y_to   = $urandom_range(63);
    glyph  = $urandom_range(255);
    if (kind >= 55 && kind < 80) begin
      // Short line; offsets wrap around the screen edge.
      x_to = x_from + $urandom_range(6) - 3;
      y_to = y_from + $urandom_range(6) - 3;
    end else if (kind >= 80 && kind < 90) begin
      len = $urandom_range(63 - ((x_from > y_from) ? x_from : y_from));
      case ($urandom_range(2))
        0: begin
          x_to = x_from + len;
          y_to = y_from;
        end
        1: begin
          x_to = x_from;
          y_to = y_from + len;
        end
        default: begin
          x_to = x_from + len;
          y_to = y_from + len;
        end
      endcase
    end else if (kind >= 90) begin
      x_to = x_from;
      y_to = y_from;
    end
    return pack_line(x_from[dda_pkg::FIELD_W-1:0], y_from[dda_pkg::FIELD_W-1:0],
                     x_to[dda_pkg::FIELD_W-1:0], y_to[dda_pkg::FIELD_W-1:0],
                     glyph[dda_pkg::GLYPH_W-1:0]);
  endfunction

  // Offer one line and return once its transaction has been accepted.
  task automatic send_line(input logic [31:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  initial begin
    wait (rst_ni);
    @(posedge clk_i);

    // Directed lines: single points, full-screen edges, diagonals both ways,
    // shallow and steep slopes, negative slopes and alternating bit patterns.
    send_line(pack_line(0, 0, 0, 0, 8'h00));
    send_line(pack_line(63, 63, 63, 63, 8'hFF));
    send_line(pack_line(0, 0, 63, 0, 8'hA5));
    send_line(pack_line(63, 0, 0, 0, 8'h5A));
    send_line(pack_line(0, 0, 0, 63, 8'h01));
    send_line(pack_line(0, 63, 0, 0, 8'h80));
    send_line(pack_line(0, 0, 63, 63, 8'h55));
    send_line(pack_line(63, 63, 0, 0, 8'hAA));
    send_line(pack_line(0, 63, 63, 0, 8'h0F));
    send_line(pack_line(63, 0, 0, 63, 8'hF0));
    send_line(pack_line(0, 0, 63, 1, 8'h33));
    send_line(pack_line(63, 1, 0, 0, 8'hCC));
    send_line(pack_line(5, 0, 6, 63, 8'h7E));
    send_line(pack_line(40, 20, 3, 51, 8'h81));
    send_line(pack_line(10, 10, 11, 11, 8'h42));
    send_line(pack_line(21, 42, 42, 21, 8'h3C));
    send_line(pack_line(42, 21, 21, 42, 8'hC3));

    // Random lines: slow receiver first, then slow sender.
    repeat (LINES_PER_PHASE) send_line(random_line());
    send_idle_pct = 59;
    recv_idle_pct = 6;
    repeat (LINES_PER_PHASE) send_line(random_line());

    // No idling on either side, starting under a long output stall.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_go = 1'b1;
    repeat (LINES_PER_PHASE) send_line(random_line());
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    // Drain every predicted pixel, then watch for stray output.
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d lines and %0d pixels: corner lines, random lines and", lines_done,
             pixels_done);
    $display("single points under sender and receiver idling plus a long output stall.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== dda_line_rasterizer.f =====
+incdir+sv
sv/dda_pkg.sv
sv/dda_axis_unit.sv
sv/dda_line_rasterizer.sv
sim/dda_pixel_checker.sv
sim/testbench.sv
